@@ rtl/pulse_period_tachometer_macros.svh @@
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef PULSE_PERIOD_TACHOMETER_MACROS_SVH
`define PULSE_PERIOD_TACHOMETER_MACROS_SVH

// Same-cycle implication.
`define PPT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PPT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ppt_pkg.sv @@
package ppt_pkg;

    localparam int DEFAULT_SAMPLES   = 8;
    localparam int DEFAULT_TIME_BITS = 48;

    localparam int INTV_W    = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int PPR_W     = 8;
    localparam int CIRC_W    = 16;
    localparam int RES_W     = 32;
    localparam int NUM_W     = 36;
    localparam int DEN_W     = 32;
    localparam int SPD_PROD_W = 35;

    localparam logic [NUM_W-1:0]      RPM_NUM   = 36'd6000000000;
    localparam logic [SPD_PROD_W-1:0] SPD_SCALE = 35'd360000;

    localparam logic [CFG_W-1:0]  DEBOUNCE_RST = 24'd10000;
    localparam logic [CFG_W-1:0]  STOP_RST     = 24'd1500000;
    localparam logic [CFG_W-1:0]  PERIOD_RST   = 24'd100000;
    localparam logic [PPR_W-1:0]  PPR_RST      = 8'd1;
    localparam logic [CIRC_W-1:0] CIRC_RST     = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE      = 3'd0,
        REG_STOP_TIMEOUT  = 3'd1,
        REG_UPDATE_PERIOD = 3'd2,
        REG_PULSES_PER_REV = 3'd3,
        REG_WHEEL_CIRC    = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        CMD_PULSE  = 1'b0,
        CMD_UPDATE = 1'b1
    } item_cmd_t;

    typedef enum logic [1:0] {
        DIV_AVG = 2'd0,
        DIV_RPM = 2'd1,
        DIV_SPD = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     calc_diff;
        logic     pulse_commit;
        logic     upd_stamp;
        logic     stop_clear;
        logic     walk_clear;
        logic     walk_step;
        logic     div_start;
        div_sel_t div_sel;
        logic     store_avg;
        logic     mul;
        logic     store_rpm;
        logic     store_spd;
        logic     out_load;
        logic     out_fresh;
        logic     out_stopped;
    } ppt_cmd_t;

    typedef struct packed {
        logic is_update;
        logic early;
        logic timed_out;
        logic walk_done;
        logic count_zero;
        logic div_done;
        logic out_full;
    } ppt_status_t;

    function automatic logic [RES_W-1:0] sat_res(input logic [NUM_W-1:0] q);
        return (|q[NUM_W-1:RES_W]) ? '1 : q[RES_W-1:0];
    endfunction

endpackage

@@ rtl/ppt_stream_if.sv @@
interface ppt_in_if #(
    parameter int TIME_BITS = ppt_pkg::DEFAULT_TIME_BITS
);
    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [TIME_BITS-1:0] now_us;

    modport source (output valid, output cmd, output now_us, input ready);
    modport sink   (input valid, input cmd, input now_us, output ready);
endinterface

interface ppt_out_if;
    logic                        valid;
    logic                        ready;
    logic [ppt_pkg::RES_W-1:0]   rpm_x100;
    logic [ppt_pkg::RES_W-1:0]   speed_x100;
    logic                        fresh;
    logic                        stopped;

    modport source (output valid, output rpm_x100, output speed_x100, output fresh,
                    output stopped, input ready);
    modport sink   (input valid, input rpm_x100, input speed_x100, input fresh,
                    input stopped, output ready);
endinterface

@@ rtl/ppt_ram.sv @@
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ppt_div.sv @@
// Restoring divider, one quotient bit per cycle. Zero divisor gives all ones.
module ppt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ppt_pkg::NUM_W-1:0] num,
    input  logic [ppt_pkg::DEN_W-1:0] den,
    output logic [ppt_pkg::NUM_W-1:0] quot,
    output logic                      done
);

    localparam int NW  = ppt_pkg::NUM_W;
    localparam int DW  = ppt_pkg::DEN_W;
    localparam int CW  = $clog2(NW + 1);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, quo_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign quot = quo_reg;
    assign done = done_reg;

endmodule

@@ rtl/ppt_dp.sv @@
module ppt_dp #(
    parameter int SAMPLES   = ppt_pkg::DEFAULT_SAMPLES,
    parameter int TIME_BITS = ppt_pkg::DEFAULT_TIME_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppt_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_cmd,
    input  logic [TIME_BITS-1:0]          in_now,
    ppt_out_if.source                     results,
    input  ppt_pkg::ppt_cmd_t             cmd,
    output ppt_pkg::ppt_status_t          status
);

    localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int SUM_W = ppt_pkg::INTV_W + CNT_W;
    localparam int IW    = ppt_pkg::INTV_W;
    localparam int RW    = ppt_pkg::RES_W;

    // configuration
    logic [ppt_pkg::CFG_W-1:0]  deb_reg;
    logic [ppt_pkg::CFG_W-1:0]  stop_reg;
    logic [ppt_pkg::CFG_W-1:0]  period_reg;
    logic [ppt_pkg::PPR_W-1:0]  ppr_reg;
    logic [ppt_pkg::CIRC_W-1:0] circ_reg;

    // item and timing
    logic                 cmd_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] last_pulse_reg;
    logic [TIME_BITS-1:0] last_upd_reg;
    logic [TIME_BITS-1:0] diff_pulse_reg;
    logic [TIME_BITS-1:0] diff_upd_reg;
    logic                 gap_gt_deb;
    logic                 timed_out;

    // ring
    logic [SAMPLES-1:0] valid_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic               ring_we;
    logic               ring_re;
    logic [IW-1:0]      ring_rdata;

    // averaging walk
    logic [CNT_W-1:0] wcnt_reg;
    logic             walk_more;
    logic             acc_vld_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] count_reg;

    // arithmetic
    logic [IW-1:0]                   avg_reg;
    logic [ppt_pkg::DEN_W-1:0]       den_reg;
    logic [ppt_pkg::NUM_W-1:0]       spd_num_reg;
    logic [ppt_pkg::SPD_PROD_W-1:0]  spd_prod;
    logic [ppt_pkg::NUM_W-1:0]       div_num;
    logic [ppt_pkg::DEN_W-1:0]       div_den;
    logic [ppt_pkg::NUM_W-1:0]       div_quot;
    logic                            div_done;
    logic [RW-1:0]                   held_rpm_reg;
    logic [RW-1:0]                   held_spd_reg;

    // result register
    logic          out_valid_reg;
    logic [RW-1:0] out_rpm_reg;
    logic [RW-1:0] out_spd_reg;
    logic          out_fresh_reg;
    logic          out_stopped_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_reg    <= ppt_pkg::DEBOUNCE_RST;
            stop_reg   <= ppt_pkg::STOP_RST;
            period_reg <= ppt_pkg::PERIOD_RST;
            ppr_reg    <= ppt_pkg::PPR_RST;
            circ_reg   <= ppt_pkg::CIRC_RST;
        end
        else if (cfg_we)
        begin
            unique case (ppt_pkg::cfg_reg_t'(cfg_index))
                ppt_pkg::REG_DEBOUNCE:       deb_reg    <= cfg_data;
                ppt_pkg::REG_STOP_TIMEOUT:   stop_reg   <= cfg_data;
                ppt_pkg::REG_UPDATE_PERIOD:  period_reg <= cfg_data;
                ppt_pkg::REG_PULSES_PER_REV: ppr_reg    <= cfg_data[ppt_pkg::PPR_W-1:0];
                ppt_pkg::REG_WHEEL_CIRC:     circ_reg   <= cfg_data[ppt_pkg::CIRC_W-1:0];
                default: ;
            endcase
        end
    end

    assign gap_gt_deb = diff_pulse_reg > TIME_BITS'(deb_reg);
    assign timed_out  = diff_pulse_reg > TIME_BITS'(stop_reg);

    assign ring_we   = cmd.pulse_commit && gap_gt_deb && !timed_out;
    assign walk_more = wcnt_reg < CNT_W'(SAMPLES);
    assign ring_re   = cmd.walk_step && walk_more;

    ppt_ram #(
        .WIDTH (IW),
        .DEPTH (SAMPLES)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (pos_reg),
        .wdata (diff_pulse_reg[IW-1:0]),
        .re    (ring_re),
        .raddr (wcnt_reg[IDX_W-1:0]),
        .rdata (ring_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pulse_reg <= '0;
            last_upd_reg   <= '0;
            valid_reg      <= '0;
            pos_reg        <= '0;
            held_rpm_reg   <= '0;
            held_spd_reg   <= '0;
        end
        else
        begin
            if (cmd.pulse_commit && gap_gt_deb)
            begin
                last_pulse_reg <= now_reg;
            end
            if (ring_we)
            begin
                valid_reg[pos_reg] <= 1'b1;
                pos_reg <= (pos_reg == IDX_W'(SAMPLES - 1)) ? '0 : pos_reg + 1'b1;
            end
            if (cmd.upd_stamp)
            begin
                last_upd_reg <= now_reg;
            end
            if (cmd.stop_clear)
            begin
                valid_reg    <= '0;
                pos_reg      <= '0;
                held_rpm_reg <= '0;
                held_spd_reg <= '0;
            end
            if (cmd.store_rpm)
            begin
                held_rpm_reg <= ppt_pkg::sat_res(div_quot);
            end
            if (cmd.store_spd)
            begin
                held_spd_reg <= ppt_pkg::sat_res(div_quot);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg <= in_cmd;
            now_reg <= in_now;
        end
        if (cmd.calc_diff)
        begin
            diff_pulse_reg <= now_reg - last_pulse_reg;
            diff_upd_reg   <= now_reg - last_upd_reg;
        end
        if (cmd.walk_clear)
        begin
            wcnt_reg    <= '0;
            acc_vld_reg <= 1'b0;
            sum_reg     <= '0;
            count_reg   <= '0;
        end
        else if (cmd.walk_step)
        begin
            if (walk_more)
            begin
                wcnt_reg <= wcnt_reg + 1'b1;
            end
            acc_vld_reg <= walk_more && valid_reg[wcnt_reg[IDX_W-1:0]];
            if (acc_vld_reg)
            begin
                sum_reg   <= sum_reg + SUM_W'(ring_rdata);
                count_reg <= count_reg + 1'b1;
            end
        end
        if (cmd.store_avg)
        begin
            avg_reg <= div_quot[IW-1:0];
        end
        if (cmd.mul)
        begin
            den_reg     <= ppt_pkg::DEN_W'(ppr_reg) * ppt_pkg::DEN_W'(avg_reg);
            spd_num_reg <= ppt_pkg::NUM_W'(spd_prod);
        end
    end

    assign spd_prod = ppt_pkg::SPD_PROD_W'(circ_reg) * ppt_pkg::SPD_SCALE;

    always_comb
    begin
        div_num = ppt_pkg::NUM_W'(sum_reg);
        div_den = ppt_pkg::DEN_W'(count_reg);
        unique case (cmd.div_sel)
            ppt_pkg::DIV_AVG:
            begin
                div_num = ppt_pkg::NUM_W'(sum_reg);
                div_den = ppt_pkg::DEN_W'(count_reg);
            end
            ppt_pkg::DIV_RPM:
            begin
                div_num = ppt_pkg::RPM_NUM;
                div_den = den_reg;
            end
            ppt_pkg::DIV_SPD:
            begin
                div_num = spd_num_reg;
                div_den = den_reg;
            end
            default: ;
        endcase
    end

    ppt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .done  (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_rpm_reg     <= held_rpm_reg;
            out_spd_reg     <= held_spd_reg;
            out_fresh_reg   <= cmd.out_fresh;
            out_stopped_reg <= cmd.out_stopped;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.rpm_x100   = out_rpm_reg;
    assign results.speed_x100 = out_spd_reg;
    assign results.fresh      = out_fresh_reg;
    assign results.stopped    = out_stopped_reg;

    assign status.is_update  = (cmd_reg == ppt_pkg::CMD_UPDATE);
    assign status.early      = diff_upd_reg < TIME_BITS'(period_reg);
    assign status.timed_out  = timed_out;
    assign status.walk_done  = !walk_more;
    assign status.count_zero = (count_reg == '0);
    assign status.div_done   = div_done;
    assign status.out_full   = out_valid_reg;

endmodule

@@ rtl/ppt_ctrl.sv @@
module ppt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ppt_pkg::ppt_status_t status,
    output ppt_pkg::ppt_cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DIFF     = 12'b0000_0000_0010,
        S_DECIDE   = 12'b0000_0000_0100,
        S_WALK     = 12'b0000_0000_1000,
        S_CNT_CHK  = 12'b0000_0001_0000,
        S_AVG_WAIT = 12'b0000_0010_0000,
        S_MUL      = 12'b0000_0100_0000,
        S_RPM_GO   = 12'b0000_1000_0000,
        S_RPM_WAIT = 12'b0001_0000_0000,
        S_SPD_GO   = 12'b0010_0000_0000,
        S_SPD_WAIT = 12'b0100_0000_0000,
        S_OUT      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   fresh_reg;
    logic   fresh_next;
    logic   stopped_reg;
    logic   stopped_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fresh_reg   <= 1'b0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fresh_reg   <= fresh_next;
            stopped_reg <= stopped_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        fresh_next   = fresh_reg;
        stopped_next = stopped_reg;
        cmd          = '0;
        cmd.div_sel  = ppt_pkg::DIV_AVG;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!status.is_update)
                begin
                    cmd.pulse_commit = 1'b1;
                    state_next       = S_IDLE;
                end
                else if (status.early)
                begin
                    fresh_next   = 1'b0;
                    stopped_next = 1'b0;
                    state_next   = S_OUT;
                end
                else if (status.timed_out)
                begin
                    cmd.upd_stamp  = 1'b1;
                    cmd.stop_clear = 1'b1;
                    fresh_next     = 1'b1;
                    stopped_next   = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.upd_stamp  = 1'b1;
                    cmd.walk_clear = 1'b1;
                    state_next     = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                begin
                    state_next = S_CNT_CHK;
                end
            end
            S_CNT_CHK:
            begin
                if (status.count_zero)
                begin
                    // nothing to average: hold previous values
                    fresh_next   = 1'b0;
                    stopped_next = 1'b0;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ppt_pkg::DIV_AVG;
                    state_next    = S_AVG_WAIT;
                end
            end
            S_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store_avg = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RPM_GO;
            end
            S_RPM_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ppt_pkg::DIV_RPM;
                state_next    = S_RPM_WAIT;
            end
            S_RPM_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store_rpm = 1'b1;
                    state_next    = S_SPD_GO;
                end
            end
            S_SPD_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = ppt_pkg::DIV_SPD;
                state_next    = S_SPD_WAIT;
            end
            S_SPD_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.store_spd = 1'b1;
                    fresh_next    = 1'b1;
                    stopped_next  = 1'b0;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_fresh   = fresh_reg;
                    cmd.out_stopped = stopped_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/pulse_period_tachometer.sv @@
// One item at a time. A pulse item goes through the difference and decide states
// before ready again. An early or stop-timeout update goes from the decide state
// straight to the output state; a full update walks the ring of SAMPLES entries
// and makes three runs of the shared 36-step divider.
// The result register lets the next item in while a result waits to be taken.
// rst_n is asynchronous: config to defaults, ring valid bits and timing state cleared.
module pulse_period_tachometer #(
    parameter int SAMPLES   = ppt_pkg::DEFAULT_SAMPLES,
    parameter int TIME_BITS = ppt_pkg::DEFAULT_TIME_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppt_pkg::CFG_W-1:0]     cfg_data,
    ppt_in_if.sink                        items,
    ppt_out_if.source                     results
);

    ppt_pkg::ppt_cmd_t    cmd;
    ppt_pkg::ppt_status_t status;

    ppt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_ready (items.ready),
        .status   (status),
        .cmd      (cmd)
    );

    ppt_dp #(
        .SAMPLES   (SAMPLES),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (items.cmd),
        .in_now    (items.now_us),
        .results   (results),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ rtl/ppt_checker.sv @@
`include "pulse_period_tachometer_macros.svh"

module ppt_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [ppt_pkg::RES_W-1:0] rpm_x100,
    input logic [ppt_pkg::RES_W-1:0] speed_x100,
    input logic                      fresh,
    input logic                      stopped
);

    // a stop result is always a fresh zero
    `PPT_ASSERT_IMP(a_stop_zero, out_valid && stopped, fresh && rpm_x100 == '0 && speed_x100 == '0, "stop result not fresh zero")

    // one item at a time: busy right after an accept
    `PPT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

    // no back-to-back results from a sequential engine
    `PPT_ASSERT_NXT(a_result_gap, out_valid && out_ready, !out_valid, "result followed without a gap")

    `PPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rpm_x100) && $stable(speed_x100), "stalled result changed")

endmodule

bind pulse_period_tachometer ppt_checker u_ppt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (items.valid),
    .in_ready   (items.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .rpm_x100   (results.rpm_x100),
    .speed_x100 (results.speed_x100),
    .fresh      (results.fresh),
    .stopped    (results.stopped)
);

@@ verif/pulse_period_tachometer_tb.sv @@
module pulse_period_tachometer_tb;
    import ppt_pkg::*;

    localparam int TW           = DEFAULT_TIME_BITS;
    localparam int DRAIN_CYCLES = 200;
    localparam int RAND_PHASES  = 13;
    localparam int PHASE_ITEMS  = 150;
    localparam int PLAN_ROWS    = 29;

    // register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

    typedef struct packed {
        logic [RES_W-1:0] rpm_x100;
        logic [RES_W-1:0] speed_x100;
        logic             fresh;
        logic             stopped;
    } tach_reading_t;

    typedef struct packed {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        item_cmd_t            cmd;
        logic [TW-1:0]        now;
        bit                   typed;
        tach_reading_t        want;
    } plan_row_t;

    typedef enum {CFG_TYPICAL, CFG_EXTREME, CFG_ANY, CFG_TIGHT} cfg_mix_t;

    localparam bit ROW_CFG  = 1'b1;
    localparam bit ROW_ITEM = 1'b0;
    localparam bit TYPED    = 1'b1;
    localparam bit PRED     = 1'b0;

    localparam tach_reading_t QUIET   = '{32'd0, 32'd0, 1'b0, 1'b0};
    localparam tach_reading_t STOP_RD = '{32'd0, 32'd0, 1'b1, 1'b1};
    localparam tach_reading_t SAT_RD  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0};

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd0, TYPED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd100000, TYPED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_PULSE, 48'd110000, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_PULSE, 48'd120000, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_PULSE, 48'd130000, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd150000, TYPED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd200000, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd250000, PRED, QUIET},
        // ppr write truncates to zero: divisor is zero
        '{ROW_CFG, REG_PULSES_PER_REV, 24'h000100, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd300000, TYPED, SAT_RD},
        '{ROW_CFG, REG_PULSES_PER_REV, 24'h000001, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_CFG, REG_WHEEL_CIRC, 24'h010000, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd400000, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd2000000, TYPED, STOP_RD},
        '{ROW_CFG, REG_DEBOUNCE, 24'h000000, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_CFG, REG_WHEEL_CIRC, 24'h00FFFF, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_PULSE, 48'd2000010, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_PULSE, 48'd2000011, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_PULSE, 48'd2000012, PRED, QUIET},
        // average interval of one us saturates both outputs
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'd2100000, TYPED, SAT_RD},
        '{ROW_CFG, REG_DEBOUNCE, 24'hFFFFFE, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_CFG, REG_STOP_TIMEOUT, 24'hFFFFFF, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_CFG, REG_UPDATE_PERIOD, 24'h000001, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_CFG, REG_SPARE_A, 24'h000000, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_CFG, REG_SPARE_B, 24'hFFFFFF, CMD_PULSE, 48'd0, PRED, QUIET},
        '{ROW_CFG, REG_SPARE_C, 24'h000001, CMD_PULSE, 48'd0, PRED, QUIET},
        // longest interval, stored across the timestamp wrap
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_PULSE, 48'hFFFF_FFFF_FFF0, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_PULSE, 48'h0000_00FF_FFEF, PRED, QUIET},
        '{ROW_ITEM, REG_DEBOUNCE, 24'd0, CMD_UPDATE, 48'h0000_00FF_FFF4, PRED, QUIET}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    ppt_in_if  ev_ch ();
    ppt_out_if rd_ch ();

    pulse_period_tachometer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (ev_ch),
        .results   (rd_ch)
    );

    // predictor state
    logic [CFG_W-1:0]  cfg_debounce = DEBOUNCE_RST;
    logic [CFG_W-1:0]  cfg_stop     = STOP_RST;
    logic [CFG_W-1:0]  cfg_period   = PERIOD_RST;
    logic [PPR_W-1:0]  cfg_ppr      = PPR_RST;
    logic [CIRC_W-1:0] cfg_circ     = CIRC_RST;
    logic [INTV_W-1:0] gap_ring [DEFAULT_SAMPLES] = '{default: '0};
    int                ring_slot   = 0;
    logic [TW-1:0]     last_pulse  = '0;
    logic [TW-1:0]     last_update = '0;
    logic [RES_W-1:0]  held_rpm    = '0;
    logic [RES_W-1:0]  held_speed  = '0;

    tach_reading_t reading_q [$];
    tach_reading_t due;
    int            errors  = 0;
    bit            busy    = 1'b0;
    bit            tx_stall = 1'b1;
    bit            rx_stall = 1'b1;
    bit            rx_took = 1'b0;
    int unsigned   rx_wait = 0;

    function automatic logic [RES_W-1:0] clamp_quotient(input longint unsigned num,
                                                        input longint unsigned den);
        longint unsigned q;
        if (den == 64'd0)
            return '1;
        q = num / den;
        return (q > 64'hFFFF_FFFF) ? '1 : q[RES_W-1:0];
    endfunction

    // returns 1 when the item yields a reading
    function automatic bit tach_predict(input item_cmd_t cmd, input logic [TW-1:0] now,
                                        output tach_reading_t rd);
        logic [TW-1:0]   since;
        longint unsigned sum;
        longint unsigned cnt;
        longint unsigned den;
        sum = 0;
        cnt = 0;
        rd = '{held_rpm, held_speed, 1'b0, 1'b0};
        if (cmd == CMD_PULSE)
        begin
            since = now - last_pulse;
            if (since > TW'(cfg_debounce))
            begin
                last_pulse = now;
                if (since <= TW'(cfg_stop))
                begin
                    gap_ring[ring_slot] = since[INTV_W-1:0];
                    ring_slot = (ring_slot + 1) % DEFAULT_SAMPLES;
                end
            end
            return 1'b0;
        end
        since = now - last_update;
        if (since < TW'(cfg_period))
            return 1'b1;
        last_update = now;
        since = now - last_pulse;
        if (since > TW'(cfg_stop))
        begin
            foreach (gap_ring[j])
                gap_ring[j] = '0;
            ring_slot = 0;
            held_rpm = '0;
            held_speed = '0;
            rd = STOP_RD;
            return 1'b1;
        end
        foreach (gap_ring[j])
        begin
            if (gap_ring[j] != '0)
            begin
                sum += 64'(gap_ring[j]);
                cnt++;
            end
        end
        if (cnt == 64'd0)
            return 1'b1;
        den = 64'(cfg_ppr) * (sum / cnt);
        held_rpm = clamp_quotient(64'd6000000000, den);
        held_speed = clamp_quotient(64'd360000 * 64'(cfg_circ), den);
        rd = '{held_rpm, held_speed, 1'b1, 1'b0};
        return 1'b1;
    endfunction

    function automatic logic [CFG_W-1:0] pick3(input logic [CFG_W-1:0] a,
                                               input logic [CFG_W-1:0] b,
                                               input logic [CFG_W-1:0] c);
        int unsigned r;
        r = $urandom_range(0, 2);
        return (r == 0) ? a : (r == 1) ? b : c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_DEBOUNCE:       cfg_debounce = data;
            REG_STOP_TIMEOUT:   cfg_stop = data;
            REG_UPDATE_PERIOD:  cfg_period = data;
            REG_PULSES_PER_REV: cfg_ppr = data[PPR_W-1:0];
            REG_WHEEL_CIRC:     cfg_circ = data[CIRC_W-1:0];
            default: ;
        endcase
    endtask

    // entered and left at a falling edge; valid stays up for back-to-back items
    task automatic send_item(input item_cmd_t cmd, input logic [TW-1:0] now,
                             input bit typed, input tach_reading_t typed_rd);
        int unsigned   pause;
        tach_reading_t rd;
        pause = tx_stall ? $urandom_range(0, 14) : 0;
        if (pause > 0)
        begin
            ev_ch.valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        ev_ch.valid <= 1'b1;
        ev_ch.cmd <= cmd;
        ev_ch.now_us <= now;
        @(posedge clk);
        while (!ev_ch.ready)
            @(posedge clk);
        if (tach_predict(cmd, now, rd))
            reading_q.push_back(typed ? typed_rd : rd);
        busy = 1'b1;
        @(negedge clk);
    endtask

    // pulses give no reading, so let the block finish after the last one
    task automatic settle();
        ev_ch.valid <= 1'b0;
        while (reading_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        busy = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("pulse_period_tachometer_tb: FAIL");
        $finish;
    end

    always @(negedge clk)
    begin
        if (rx_took)
        begin
            rx_took = 1'b0;
            rx_wait = rx_stall ? $urandom_range(0, 14) : 0;
        end
        if (rx_wait > 0)
        begin
            rd_ch.ready <= 1'b0;
            rx_wait--;
        end
        else
            rd_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rd_ch.valid && rd_ch.ready)
        begin
            rx_took = 1'b1;
            if (reading_q.size() == 0)
            begin
                $error("unexpected item: rpm_x100 %0d speed_x100 %0d",
                       rd_ch.rpm_x100, rd_ch.speed_x100);
                errors++;
            end
            else
            begin
                due = reading_q.pop_front();
                if (rd_ch.rpm_x100 !== due.rpm_x100)
                begin
                    $error("rpm_x100: expected %0d, got %0d", due.rpm_x100, rd_ch.rpm_x100);
                    errors++;
                end
                if (rd_ch.speed_x100 !== due.speed_x100)
                begin
                    $error("speed_x100: expected %0d, got %0d",
                           due.speed_x100, rd_ch.speed_x100);
                    errors++;
                end
                if (rd_ch.fresh !== due.fresh)
                begin
                    $error("fresh: expected %0d, got %0d", due.fresh, rd_ch.fresh);
                    errors++;
                end
                if (rd_ch.stopped !== due.stopped)
                begin
                    $error("stopped: expected %0d, got %0d", due.stopped, rd_ch.stopped);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int            i;
        int            ph;
        int            k;
        int unsigned   roll;
        int unsigned   step;
        int unsigned   deb;
        int unsigned   stp;
        int unsigned   per;
        logic [TW-1:0] t;
        logic [TW-1:0] now;
        item_cmd_t     cmd;
        cfg_mix_t      mix;
        logic [CFG_W-1:0] w_deb;
        logic [CFG_W-1:0] w_stop;
        logic [CFG_W-1:0] w_per;
        logic [CFG_W-1:0] w_ppr;
        logic [CFG_W-1:0] w_circ;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_DEBOUNCE;
        cfg_data = '0;
        ev_ch.valid = 1'b0;
        ev_ch.cmd = CMD_PULSE;
        ev_ch.now_us = '0;
        rd_ch.ready = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < PLAN_ROWS; i++)
        begin
            if (plan[i].is_cfg)
            begin
                if (busy)
                    settle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_item(plan[i].cmd, plan[i].now, plan[i].typed, plan[i].want);
        end

        t = 48'd5000000;
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            mix = cfg_mix_t'($urandom_range(0, 3));
            case (mix)
                CFG_TYPICAL:
                begin
                    w_deb  = CFG_W'($urandom_range(0, 5000));
                    w_stop = CFG_W'($urandom_range(200000, 3000000));
                    w_per  = CFG_W'($urandom_range(5000, 100000));
                    w_ppr  = CFG_W'($urandom_range(1, 255));
                    w_circ = CFG_W'($urandom_range(1, 65535));
                end
                CFG_EXTREME:
                begin
                    w_deb  = pick3(24'h000000, 24'h000001, 24'hFFFFFF);
                    w_stop = pick3(24'h000000, 24'h000001, 24'hFFFFFF);
                    w_per  = pick3(24'h000000, 24'h000001, 24'hFFFFFF);
                    w_ppr  = pick3(24'h000100, 24'h000001, 24'h0000FF);
                    w_circ = pick3(24'h010000, 24'h000001, 24'h00FFFF);
                end
                CFG_ANY:
                begin
                    w_deb  = CFG_W'($urandom);
                    w_stop = CFG_W'($urandom);
                    w_per  = CFG_W'($urandom);
                    w_ppr  = CFG_W'($urandom);
                    w_circ = CFG_W'($urandom);
                end
                default:
                begin
                    w_deb  = CFG_W'($urandom_range(0, 20));
                    w_stop = CFG_W'($urandom_range(50, 400));
                    w_per  = CFG_W'($urandom_range(1, 200));
                    w_ppr  = CFG_W'($urandom_range(1, 255));
                    w_circ = CFG_W'($urandom_range(0, 65535));
                end
            endcase
            write_reg(REG_DEBOUNCE, w_deb);
            write_reg(REG_STOP_TIMEOUT, w_stop);
            write_reg(REG_UPDATE_PERIOD, w_per);
            write_reg(REG_PULSES_PER_REV, w_ppr);
            write_reg(REG_WHEEL_CIRC, w_circ);
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'(pick3(CFG_W'(REG_SPARE_A), CFG_W'(REG_SPARE_B),
                                           CFG_W'(REG_SPARE_C))),
                          CFG_W'($urandom));

            tx_stall = ($urandom_range(0, 3) != 0);
            rx_stall = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 3);
            if (roll == 0)
                t = 48'hFFFF_FFFF_FFFF - TW'($urandom_range(0, 30000000));
            else if (roll == 1)
                t = {16'($urandom), $urandom};

            deb = 32'(cfg_debounce);
            stp = 32'(cfg_stop);
            per = 32'(cfg_period);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    // out-of-sequence timestamp
                    cmd = item_cmd_t'($urandom_range(0, 1));
                    now = {16'($urandom), $urandom};
                end
                else
                begin
                    cmd = ($urandom_range(0, 2) == 0) ? CMD_UPDATE : CMD_PULSE;
                    roll = $urandom_range(0, 9);
                    if (cmd == CMD_PULSE)
                    begin
                        if (roll < 2)
                            step = $urandom_range(0, deb);
                        else if (roll < 9)
                            step = (stp / 3 > deb) ? $urandom_range(deb + 1, stp / 3)
                                                   : deb + 1 + $urandom_range(0, 3);
                        else
                            step = stp + 1 + $urandom_range(0, stp);
                    end
                    else if (roll < 2)
                        step = $urandom_range(0, per);
                    else
                        step = $urandom_range(per, 2 * per);
                    t = t + TW'(step);
                    now = t;
                end
                send_item(cmd, now, PRED, QUIET);
            end
        end

        settle();
        if (errors == 0 && reading_q.size() == 0)
            $display("pulse_period_tachometer_tb: PASS");
        else
            $display("pulse_period_tachometer_tb: FAIL");
        $finish;
    end

endmodule
